>>> src/pfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared types, layout codes and helpers of the pixel format decoder.
// ----------------------------------------------------------------------------
package pfd_pkg;

  typedef enum logic [4:0] {
    FMT_L_U8      = 5'd0,
    FMT_L_F16     = 5'd1,
    FMT_L_F32     = 5'd2,
    FMT_LA_U8     = 5'd3,
    FMT_LA_F16    = 5'd4,
    FMT_LA_F32    = 5'd5,
    FMT_RGB_565   = 5'd6,
    FMT_BGR_565   = 5'd7,
    FMT_RGB_U8    = 5'd8,
    FMT_BGR_U8    = 5'd9,
    FMT_RGB_F16   = 5'd10,
    FMT_BGR_F16   = 5'd11,
    FMT_RGB_F32   = 5'd12,
    FMT_BGR_F32   = 5'd13,
    FMT_RGBA_5551 = 5'd14,
    FMT_BGRA_5551 = 5'd15,
    FMT_RGBA_4444 = 5'd16,
    FMT_BGRA_4444 = 5'd17,
    FMT_RGBA_U8   = 5'd18,
    FMT_BGRA_U8   = 5'd19,
    FMT_RGBA_F16  = 5'd20,
    FMT_BGRA_F16  = 5'd21,
    FMT_RGBA_F32  = 5'd22,
    FMT_BGRA_F32  = 5'd23
  } fmt_t;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_HALF   = 2'd1,
    KIND_SINGLE = 2'd2
  } kind_t;

  localparam int FMT_BITS        = 5;
  localparam int CHAN_BITS       = 32;
  localparam int LANES           = 4;
  localparam int INDEX_FIELD     = 16;
  localparam int INDEX_BITS_DFLT = 16;
  localparam logic [FMT_BITS-1:0] FMT_RESET = FMT_RGBA_U8;

  function automatic kind_t fmt_kind(input logic [FMT_BITS-1:0] code);
    kind_t k;
    case (fmt_t'(code))
      FMT_L_F16, FMT_LA_F16, FMT_RGB_F16, FMT_BGR_F16,
      FMT_RGBA_F16, FMT_BGRA_F16: k = KIND_HALF;
      FMT_L_F32, FMT_LA_F32, FMT_RGB_F32, FMT_BGR_F32,
      FMT_RGBA_F32, FMT_BGRA_F32: k = KIND_SINGLE;
      default: k = KIND_BYTE;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

>>> src/pixel_format_to_rgba8_decoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_format_to_rgba8_decoder_core
// Decodes one stored pixel of a selectable layout into RGBA8.
//
// The input stream carries one pixel per item: its index and up to four raw
// channel words in memory order. The output stream returns the index and the
// red, green, blue and alpha bytes. The layout is chosen by the format
// register; the user writes it through cfg_we and cfg_wdata only while the
// stream is idle, which the block itself does not enforce. Four decode lanes
// convert the channel words in parallel, and a merge stage places them, or
// the fields of a packed 16-bit word, into the color. An accepted input item
// passes the lane product register and then the output register. Throughput
// is one item per cycle while the receiver does not stall. When the receiver
// stalls, the output register holds its item and one more item waits in the
// lane registers; after that the input side deasserts tready. Reset empties
// the pipeline and sets the format to RGBA_U8.
// ----------------------------------------------------------------------------
module pixel_format_to_rgba8_decoder_core #(
  parameter int INDEX_BITS = pfd_pkg::INDEX_BITS_DFLT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [4:0]   cfg_wdata,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // pixel_index[15:0], chan0[47:16], chan1[79:48], chan2[111:80], chan3[143:112]
  input  wire logic [143:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // index_out[15:0], red[23:16], green[31:24], blue[39:32], alpha[47:40]
  output logic [47:0]       m_axis_tdata
);

  localparam int IW = pfd_pkg::INDEX_FIELD;
  localparam logic [IW-1:0] INDEX_MASK =
    (INDEX_BITS >= IW) ? {IW{1'b1}} : IW'((64'd1 << INDEX_BITS) - 64'd1);

  logic [pfd_pkg::FMT_BITS-1:0] pixel_format;
  logic                         v1;
  logic [pfd_pkg::FMT_BITS-1:0] fmt1;
  logic [IW-1:0]                idx1;
  logic [15:0]                  word1;
  logic                         ready2;
  pfd_pkg::kind_t               kind;
  logic [pfd_pkg::LANES-1:0][7:0] lane_val;
  logic [7:0] red, green, blue, alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= pfd_pkg::FMT_RESET;
    end else if (cfg_we) begin
      pixel_format <= cfg_wdata;
    end
  end

  assign ready2        = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !v1 || ready2;
  assign kind          = pfd_pkg::fmt_kind(pixel_format);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s_axis_tready) begin
      v1 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      fmt1  <= pixel_format;
      idx1  <= s_axis_tdata[15:0] & INDEX_MASK;
      word1 <= s_axis_tdata[31:16];
    end
  end

  for (genvar i = 0; i < pfd_pkg::LANES; i++) begin : g_lane
    pfd_lane u_lane (
      .clk   (clk),
      .en    (s_axis_tready),
      .word  (s_axis_tdata[IW + i*pfd_pkg::CHAN_BITS +: pfd_pkg::CHAN_BITS]),
      .kind  (kind),
      .value (lane_val[i])
    );
  end

  pfd_merge u_merge (
    .fmt         (fmt1),
    .lane        (lane_val),
    .packed_word (word1),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .alpha       (alpha)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ready2) begin
      m_axis_tvalid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2) begin
      m_axis_tdata <= {alpha, blue, green, red, idx1};
    end
  end

  a_reset_empty : assert property (@(posedge clk) rst |=> !m_axis_tvalid && !v1)
    else $error("pipeline not empty after reset");

  a_full_stall : assert property (@(posedge clk) disable iff (rst)
    v1 && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while both stages are full");

  a_accept_fills : assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> v1)
    else $error("accepted item not held in lane stage");

  a_advance : assert property (@(posedge clk) disable iff (rst)
    v1 && ready2 |=> m_axis_tvalid)
    else $error("lane stage item lost on its way to the output");

endmodule
`default_nettype wire

>>> src/pfd_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfd_lane
// One channel decoder: byte, half or single element to an 8-bit value.
// ----------------------------------------------------------------------------
module pfd_lane (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [pfd_pkg::CHAN_BITS-1:0] word,
  input  wire pfd_pkg::kind_t                kind,
  output logic [7:0]                         value
);

  logic [14:0] em;
  logic [31:0] r_half;
  logic [31:0] fbits;
  logic        sgn;
  logic [7:0]  ex;
  logic [22:0] frac;
  logic [23:0] mant;
  logic        dir_c;
  logic [7:0]  val_c;

  logic        direct;
  logic [7:0]  val;
  logic [31:0] prod;
  logic [7:0]  expo;

  always_comb begin
    em = word[14:0];
    r_half = ({17'd0, em} + 32'h0001_C000) << 13;
    if (em >= 15'h7C00) begin
      r_half = r_half + 32'h3800_0000;
    end
    if (em < 15'h0400) begin
      r_half = 32'd0;
    end
    if (kind == pfd_pkg::KIND_HALF) begin
      fbits = {word[15], 31'd0} | r_half;
    end else begin
      fbits = word;
    end
    sgn  = fbits[31];
    ex   = fbits[30:23];
    frac = fbits[22:0];
    mant = {1'b1, frac};
    dir_c = 1'b1;
    val_c = 8'd0;
    if (kind == pfd_pkg::KIND_BYTE) begin
      val_c = word[7:0];
    end else if (ex == 8'hFF) begin
      val_c = (frac != 23'd0 || sgn) ? 8'd0 : 8'hFF;
    end else if (sgn || ex == 8'd0) begin
      val_c = 8'd0;
    end else begin
      dir_c = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      direct <= dir_c;
      val    <= val_c;
      prod   <= {mant, 8'd0} - {8'd0, mant};
      expo   <= ex;
    end
  end

  logic              d8;
  logic [24:0]       q;
  logic [7:0]        rem;
  logic [7:0]        half;
  logic              rnd;
  logic [25:0]       qr;
  logic signed [9:0] sh;
  logic [25:0]       qs;
  logic [7:0]        norm;

  always_comb begin
    d8   = prod[31];
    q    = d8 ? {1'b0, prod[31:8]} : prod[31:7];
    rem  = d8 ? prod[7:0] : {1'b0, prod[6:0]};
    half = d8 ? 8'h80 : 8'h40;
    rnd  = (rem > half) || (rem == half && q[0]);
    qr   = {1'b0, q} + {25'd0, rnd};
    sh   = 10'sd150 - (d8 ? 10'sd8 : 10'sd7) - $signed({2'b00, expo});
    qs   = qr >> sh[4:0];
    if (sh <= 10'sd0) begin
      norm = 8'hFF;
    end else if (sh >= 10'sd26) begin
      norm = 8'd0;
    end else if (qs > 26'd255) begin
      norm = 8'hFF;
    end else begin
      norm = qs[7:0];
    end
    value = direct ? val : norm;
  end

endmodule
`default_nettype wire

>>> src/pfd_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfd_merge
// Combines the lane values and the packed word into one RGBA8 color.
// ----------------------------------------------------------------------------
module pfd_merge (
  input  wire logic [pfd_pkg::FMT_BITS-1:0] fmt,
  input  wire logic [pfd_pkg::LANES-1:0][7:0] lane,
  input  wire logic [15:0]                  packed_word,
  output logic [7:0]                        red,
  output logic [7:0]                        green,
  output logic [7:0]                        blue,
  output logic [7:0]                        alpha
);

  logic [7:0] x;
  logic [7:0] y;
  logic       swap;

  always_comb begin
    x = 8'd0;
    y = 8'd0;
    green = 8'd0;
    alpha = 8'hFF;
    swap = fmt[0];
    case (pfd_pkg::fmt_t'(fmt))
      pfd_pkg::FMT_L_U8, pfd_pkg::FMT_L_F16, pfd_pkg::FMT_L_F32: begin
        x = lane[0];
        y = lane[0];
        green = lane[0];
        swap = 1'b0;
      end
      pfd_pkg::FMT_LA_U8, pfd_pkg::FMT_LA_F16, pfd_pkg::FMT_LA_F32: begin
        x = lane[0];
        y = lane[0];
        green = lane[0];
        alpha = lane[1];
        swap = 1'b0;
      end
      pfd_pkg::FMT_RGB_565, pfd_pkg::FMT_BGR_565: begin
        x = {packed_word[15:11], 3'd0};
        green = {packed_word[10:5], 2'd0};
        y = {packed_word[4:0], 3'd0};
        swap = (fmt == pfd_pkg::FMT_BGR_565);
      end
      pfd_pkg::FMT_RGB_U8, pfd_pkg::FMT_BGR_U8, pfd_pkg::FMT_RGB_F16,
      pfd_pkg::FMT_BGR_F16, pfd_pkg::FMT_RGB_F32, pfd_pkg::FMT_BGR_F32: begin
        x = lane[0];
        green = lane[1];
        y = lane[2];
      end
      pfd_pkg::FMT_RGBA_5551, pfd_pkg::FMT_BGRA_5551: begin
        x = {packed_word[15:11], 3'd0};
        green = {packed_word[10:6], 3'd0};
        y = {packed_word[5:1], 3'd0};
        alpha = {8{packed_word[0]}};
        swap = (fmt == pfd_pkg::FMT_BGRA_5551);
      end
      pfd_pkg::FMT_RGBA_4444, pfd_pkg::FMT_BGRA_4444: begin
        x = {2{packed_word[15:12]}};
        green = {2{packed_word[11:8]}};
        y = {2{packed_word[7:4]}};
        alpha = {2{packed_word[3:0]}};
        swap = (fmt == pfd_pkg::FMT_BGRA_4444);
      end
      pfd_pkg::FMT_RGBA_U8, pfd_pkg::FMT_BGRA_U8, pfd_pkg::FMT_RGBA_F16,
      pfd_pkg::FMT_BGRA_F16, pfd_pkg::FMT_RGBA_F32, pfd_pkg::FMT_BGRA_F32: begin
        x = lane[0];
        green = lane[1];
        y = lane[2];
        alpha = lane[3];
      end
      default: begin
        alpha = 8'd0;
        swap = 1'b0;
      end
    endcase
    red  = swap ? y : x;
    blue = swap ? x : y;
  end

endmodule
`default_nettype wire

>>> tb/tb_pixel_format_to_rgba8_decoder_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pixel_format_to_rgba8_decoder_core
// Self-checking testbench for the pixel format to RGBA8 decoder.
//
// Every layout code and the unused codes 24, 30 and 31 are loaded through the
// configuration port while the stream is idle. Directed pixels cover the
// extremes of the packed layouts and the special half and single values.
// Random pixels with shaped float content follow. Both stream sides idle at
// random, except for one stretch at full rate. A long receiver stall fills
// the pipeline. Each output item is checked field by field against a
// predictor that decodes the same pixel under the current format.
// ----------------------------------------------------------------------------
module tb_pixel_format_to_rgba8_decoder_core;

  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 150;

  typedef struct packed {
    logic [7:0]  alpha;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [15:0] index_out;
  } rgba_result_t;

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic [4:0]   cfg_wdata;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [47:0]  m_axis_tdata;

  rgba_result_t pending_colors[$];
  logic [4:0]   cur_format;
  int           src_idle_pct;
  int           sink_idle_pct;
  int           sink_hold_left;
  int           idle_cycles;
  int           errors;

  pixel_format_to_rgba8_decoder_core u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] single_to_byte(input logic [31:0] bits);
    logic [7:0]  ex;
    logic [63:0] prod;
    logic [63:0] quo;
    logic [63:0] rem;
    logic [63:0] half;
    int          d;
    int          sh;
    ex = bits[30:23];
    if (ex == 8'hFF) return (bits[22:0] != 23'd0 || bits[31]) ? 8'd0 : 8'd255;
    if (bits[31] || ex == 8'd0) return 8'd0;
    prod = 64'd255 * {40'd0, 1'b1, bits[22:0]};
    d = (prod >= 64'h8000_0000) ? 8 : 7;
    quo = prod >> d;
    rem = prod & ((64'd1 << d) - 64'd1);
    half = 64'd1 << (d - 1);
    if (rem > half || (rem == half && quo[0])) quo = quo + 64'd1;
    sh = int'(ex) - 150 + d;
    if (sh >= 0) return 8'd255;
    if (-sh >= 63) return 8'd0;
    quo = quo >> (-sh);
    return (quo > 64'd255) ? 8'd255 : quo[7:0];
  endfunction

  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [31:0] mag;
    if (h[14:0] < 15'h0400) return {h[15], 31'd0};
    mag = ({17'd0, h[14:0]} + (32'd112 << 10)) << 13;
    if (h[14:10] == 5'h1F) mag = mag + (32'd112 << 23);
    return {h[15], 31'd0} | mag;
  endfunction

  function automatic logic [7:0] decode_elem(input pfd_pkg::kind_t k,
                                             input logic [31:0] word);
    case (k)
      pfd_pkg::KIND_BYTE: return word[7:0];
      pfd_pkg::KIND_HALF: return single_to_byte(half_to_single(word[15:0]));
      default:            return single_to_byte(word);
    endcase
  endfunction

  function automatic rgba_result_t decode_pixel(input logic [4:0] fmt, input logic [15:0] idx,
                                                input logic [31:0] c0, input logic [31:0] c1,
                                                input logic [31:0] c2, input logic [31:0] c3);
    rgba_result_t   res;
    logic [15:0]    w;
    logic [4:0]     grp;
    pfd_pkg::kind_t k;
    logic [7:0]     first;
    logic [7:0]     third;
    logic           has_color;
    res = '0;
    res.index_out = idx;
    w = c0[15:0];
    has_color = 1'b1;
    first = 8'd0;
    third = 8'd0;
    if (fmt <= pfd_pkg::FMT_LA_F32) begin
      grp = fmt % 5'd3;
      k = pfd_pkg::kind_t'(grp[1:0]);
      first = decode_elem(k, c0);
      res.green = first;
      third = first;
      res.alpha = (fmt >= pfd_pkg::FMT_LA_U8) ? decode_elem(k, c1) : 8'd255;
    end else if (fmt == pfd_pkg::FMT_RGB_565 || fmt == pfd_pkg::FMT_BGR_565) begin
      first = {w[15:11], 3'b000};
      res.green = {w[10:5], 2'b00};
      third = {w[4:0], 3'b000};
      res.alpha = 8'd255;
    end else if (fmt >= pfd_pkg::FMT_RGB_U8 && fmt <= pfd_pkg::FMT_BGR_F32) begin
      grp = (fmt - pfd_pkg::FMT_RGB_U8) >> 1;
      k = pfd_pkg::kind_t'(grp[1:0]);
      first = decode_elem(k, c0);
      res.green = decode_elem(k, c1);
      third = decode_elem(k, c2);
      res.alpha = 8'd255;
    end else if (fmt == pfd_pkg::FMT_RGBA_5551 || fmt == pfd_pkg::FMT_BGRA_5551) begin
      first = {w[15:11], 3'b000};
      res.green = {w[10:6], 3'b000};
      third = {w[5:1], 3'b000};
      res.alpha = w[0] ? 8'd255 : 8'd0;
    end else if (fmt == pfd_pkg::FMT_RGBA_4444 || fmt == pfd_pkg::FMT_BGRA_4444) begin
      first = {2{w[15:12]}};
      res.green = {2{w[11:8]}};
      third = {2{w[7:4]}};
      res.alpha = {2{w[3:0]}};
    end else if (fmt >= pfd_pkg::FMT_RGBA_U8 && fmt <= pfd_pkg::FMT_BGRA_F32) begin
      grp = (fmt - pfd_pkg::FMT_RGBA_U8) >> 1;
      k = pfd_pkg::kind_t'(grp[1:0]);
      first = decode_elem(k, c0);
      res.green = decode_elem(k, c1);
      third = decode_elem(k, c2);
      res.alpha = decode_elem(k, c3);
    end else begin
      has_color = 1'b0;
    end
    if (has_color) begin
      res.red = (fmt[0] && fmt > pfd_pkg::FMT_LA_F32) ? third : first;
      res.blue = (fmt[0] && fmt > pfd_pkg::FMT_LA_F32) ? first : third;
    end
    return res;
  endfunction

  function automatic logic [31:0] rand_chan();
    logic [31:0] raw;
    logic [31:0] mant;
    logic        sgn;
    logic [4:0]  e5;
    logic [7:0]  e8;
    raw = $urandom;
    mant = $urandom;
    sgn = ($urandom_range(7) == 0);
    e5 = $urandom_range(24, 8);
    e8 = $urandom_range(136, 112);
    case ($urandom_range(4))
      0:       return raw;
      1, 2:    return {raw[31:16], sgn, e5, mant[9:0]};
      default: return {sgn, e8, mant[22:0]};
    endcase
  endfunction

  task automatic send_pixel(input logic [15:0] idx, input logic [31:0] c0, input logic [31:0] c1,
                            input logic [31:0] c2, input logic [31:0] c3);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {c3, c2, c1, c0, idx};
    do @(posedge clk); while (!s_axis_tready);
    pending_colors.push_back(decode_pixel(cur_format, idx, c0, c1, c2, c3));
  endtask

  task automatic send_random_pixels(input int count);
    for (int i = 0; i < count; i++) begin
      send_pixel($urandom, rand_chan(), rand_chan(), rand_chan(), rand_chan());
    end
  endtask

  task automatic stop_and_drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
  endtask

  task automatic set_format(input logic [4:0] fmt);
    stop_and_drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= fmt;
    @(posedge clk);
    cur_format = fmt;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_format();
    send_pixel(16'h0000, 32'h0, 32'h0, 32'h0, 32'h0);
    send_pixel(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pixel(16'h5A5A, 32'hFFFF_FF12, 32'h0000_0034, 32'h1234_5656, 32'h8000_0080);
  endtask

  task automatic test_float_specials();
    set_format(pfd_pkg::FMT_RGBA_F32);
    send_pixel(16'h0001, 32'h3F80_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000);
    send_pixel(16'h0002, 32'h0000_0001, 32'h3B80_0000, 32'h3B80_8081, 32'h4380_0000);
    send_pixel(16'h0003, 32'hBF80_0000, 32'h3F00_0000, 32'h437F_0000, 32'h7FFF_FFFF);
    set_format(pfd_pkg::FMT_RGBA_F16);
    send_pixel(16'h0004, 32'hABCD_3C00, 32'h0000_7C00, 32'h0000_FC00, 32'hFFFF_7E00);
    send_pixel(16'h0005, 32'h0000_0001, 32'h0000_83FF, 32'h0000_0400, 32'h0000_7BFF);
    send_pixel(16'h0006, 32'h0000_BC00, 32'h0000_3800, 32'h0000_1C00, 32'h0000_5BF8);
  endtask

  task automatic test_packed_layouts();
    set_format(pfd_pkg::FMT_RGB_565);
    send_pixel(16'h0010, 32'hFFFF_FFFF, 32'h1, 32'h2, 32'h3);
    send_pixel(16'h0011, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0);
    set_format(pfd_pkg::FMT_BGR_565);
    send_pixel(16'h0012, 32'h0000_F800, 32'h0, 32'h0, 32'h0);
    set_format(pfd_pkg::FMT_RGBA_5551);
    send_pixel(16'h0013, 32'h0000_FFFF, 32'h0, 32'h0, 32'h0);
    send_pixel(16'h0014, 32'h0000_0001, 32'h0, 32'h0, 32'h0);
    set_format(pfd_pkg::FMT_BGRA_5551);
    send_pixel(16'h0015, 32'h0000_F83E, 32'h0, 32'h0, 32'h0);
    set_format(pfd_pkg::FMT_RGBA_4444);
    send_pixel(16'h0016, 32'h0000_F00F, 32'h0, 32'h0, 32'h0);
    set_format(pfd_pkg::FMT_BGRA_4444);
    send_pixel(16'h0017, 32'h0000_1234, 32'h0, 32'h0, 32'h0);
  endtask

  task automatic test_gray_and_bgr();
    set_format(pfd_pkg::FMT_L_F32);
    send_pixel(16'h0020, 32'h4300_0000, 32'hFFFF_FFFF, 32'h0, 32'h0);
    set_format(pfd_pkg::FMT_LA_F16);
    send_pixel(16'h0021, 32'h0000_3C00, 32'h0000_3400, 32'h0, 32'h0);
    set_format(pfd_pkg::FMT_BGR_U8);
    send_pixel(16'h0022, 32'h0000_0011, 32'h0000_0022, 32'h0000_0033, 32'hFFFF_FFFF);
  endtask

  task automatic test_unused_code();
    set_format(5'd31);
    send_pixel(16'hBEEF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_all_formats();
    for (int f = 0; f <= 23; f++) begin
      set_format(f[4:0]);
      send_random_pixels(20);
    end
    set_format(5'd24);
    send_random_pixels(10);
    set_format(5'd30);
    send_random_pixels(10);
  endtask

  task automatic test_full_rate();
    set_format(pfd_pkg::FMT_BGRA_F16);
    src_idle_pct = 0;
    sink_idle_pct = 0;
    send_random_pixels(150);
    src_idle_pct = 24;
    sink_idle_pct = 24;
  endtask

  task automatic test_backpressure();
    set_format(pfd_pkg::FMT_RGBA_U8);
    src_idle_pct = 0;
    @(posedge clk);
    sink_hold_left = HOLD_CYCLES;
    send_random_pixels(40);
    src_idle_pct = 24;
  endtask

  task automatic report(input string field, input int want, input int got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    errors++;
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_left > 0) begin
        m_axis_tready <= 1'b0;
        sink_hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    rgba_result_t want;
    rgba_result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_colors.size() == 0) begin
        $display("%0t: unexpected output item, actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = pending_colors.pop_front();
        if (got.index_out !== want.index_out) report("index_out", want.index_out, got.index_out);
        if (got.red !== want.red) report("red", want.red, got.red);
        if (got.green !== want.green) report("green", want.green, got.green);
        if (got.blue !== want.blue) report("blue", want.blue, got.blue);
        if (got.alpha !== want.alpha) report("alpha", want.alpha, got.alpha);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_pixel_format_to_rgba8_decoder_core: errors");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 5'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cur_format = pfd_pkg::FMT_RGBA_U8;
    src_idle_pct = 24;
    sink_idle_pct = 24;
    sink_hold_left = 0;
    idle_cycles = 0;
    errors = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    test_reset_format();
    test_float_specials();
    test_packed_layouts();
    test_gray_and_bgr();
    test_unused_code();
    test_all_formats();
    test_full_rate();
    test_backpressure();
    stop_and_drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("tb_pixel_format_to_rgba8_decoder_core: clean");
    end else begin
      $display("tb_pixel_format_to_rgba8_decoder_core: errors");
    end
    $finish;
  end

endmodule
